// ----- hdl/pfc_pkg.sv -----
// Package for the Playfair digraph cipher: letter and cell types, command codes,
// controller to datapath command and status structs, and small coordinate helpers.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pfc_pkg;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_KEY    = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_PAIR   = 2'd3
   } command_type;

   localparam int unsigned LETTERS = 26;
   localparam int unsigned CELLS   = 25;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_Z = 5'd25;
   localparam cell_type   CELL_COUNT = 5'd25;
   localparam coord_type  SIDE_LAST  = 3'd4;

   typedef struct packed {
      logic clear;
      logic place_key;
      logic fill_start;
      logic fill_step;
      logic lookup;
      logic square_read;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic square_done;
      logic fill_last;
   } dp_status_type;

   // Saturates codes above Z to Z and folds J onto I.
   function automatic letter_type fold_letter(input letter_type l);
      letter_type r;
      r = (l > LETTER_Z) ? LETTER_Z : l;
      if (r == LETTER_J) begin
         r = LETTER_I;
      end
      return r;
   endfunction

   function automatic coord_type cell_row(input cell_type p);
      coord_type r;
      priority if (p < 5'd5) begin
         r = 3'd0;
      end else if (p < 5'd10) begin
         r = 3'd1;
      end else if (p < 5'd15) begin
         r = 3'd2;
      end else if (p < 5'd20) begin
         r = 3'd3;
      end else begin
         r = 3'd4;
      end
      return r;
   endfunction

   function automatic cell_type cell_index(input coord_type row, input coord_type col);
      cell_type r5;
      r5 = {2'b00, row};
      return cell_type'((r5 << 2) + r5 + {2'b00, col});
   endfunction

   function automatic coord_type cell_col(input cell_type p);
      return coord_type'(p - cell_index(cell_row(p), 3'd0));
   endfunction

   // Moves one place forward (encrypt) or back (decrypt) round a row or column.
   function automatic coord_type step_coord(input coord_type c, input logic back);
      coord_type r;
      if (back) begin
         r = (c == 3'd0) ? SIDE_LAST : coord_type'(c - 3'd1);
      end else begin
         r = (c == SIDE_LAST) ? 3'd0 : coord_type'(c + 3'd1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/pfc_req_if.sv -----
// Request channel interface: valid, ready, command and two letters.
// Depends on pfc_pkg for the command and letter types.
`default_nettype none

interface pfc_req_if import pfc_pkg::*; ();
   logic        valid;
   logic        ready;
   command_type command;
   letter_type  letter_a;
   letter_type  letter_b;

   modport source (output valid, command, letter_a, letter_b, input ready);
   modport sink   (input valid, command, letter_a, letter_b, output ready);
endinterface

`default_nettype wire

// ----- hdl/pfc_rsp_if.sv -----
// Response channel interface: valid, ready, two transformed letters and a flag.
// Depends on pfc_pkg for the letter type.
`default_nettype none

interface pfc_rsp_if import pfc_pkg::*; ();
   logic       valid;
   logic       ready;
   letter_type out_a;
   letter_type out_b;
   logic       not_ready;

   modport source (output valid, out_a, out_b, not_ready, input ready);
   modport sink   (input valid, out_a, out_b, not_ready, output ready);
endinterface

`default_nettype wire

// ----- hdl/playfair_digraph_cipher.sv -----
// Playfair digraph cipher, top level: request and response channels, direction
// register. Depends on pfc_pkg, pfc_req_if, pfc_rsp_if, pfc_controller, pfc_datapath.
//
// Requests carry a command and up to two letters (0 is A, 25 is Z). A start
// request clears the key square, a key request places one letter (J as I) if
// it is new, a finish request fills the remaining letters in alphabetical
// order, and a pair request encrypts or decrypts one digraph according to the
// direction register (csr_write_data written when csr_write_enable is high).
// Only pair requests produce a response; a pair sent before the square is
// finished returns not_ready with both letters zero.
// A finish request occupies the block while it sweeps the alphabet one letter
// per cycle. A pair request reads the letter positions on acceptance, then the
// square cells, then loads the output register and raises the response valid;
// the two memory reads lie in series, and no new request is taken until the
// response is loaded, so one pair is finished before the next is accepted.
// The response sits in an output register; if the receiver stalls, the block
// holds it and waits before loading the next one, while req_channel.ready
// stays low. Synchronous reset empties the square, clears the direction to
// encrypt and drops any pending response.
`default_nettype none

module playfair_digraph_cipher import pfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pfc_req_if.sink       req_channel,
   pfc_rsp_if.source     rsp_channel,
   input  logic          csr_write_enable,
   input  logic          csr_write_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   pfc_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_channel.valid),
      .req_command (req_channel.command),
      .req_ready   (req_channel.ready),
      .rsp_valid   (rsp_channel.valid),
      .rsp_ready   (rsp_channel.ready),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   pfc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .letter_a         (req_channel.letter_a),
      .letter_b         (req_channel.letter_b),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .out_a            (rsp_channel.out_a),
      .out_b            (rsp_channel.out_b),
      .not_ready        (rsp_channel.not_ready)
   );

endmodule

`default_nettype wire

// ----- hdl/pfc_datapath.sv -----
// Datapath: key square and letter position memories, used-letter flags, fill
// counter, pair lookup and response registers. Depends on pfc_pkg.
`default_nettype none

module pfc_datapath import pfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  letter_type    letter_a,
   input  letter_type    letter_b,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   output letter_type    out_a,
   output letter_type    out_b,
   output logic          not_ready
);

   logic [LETTERS-1:0] letter_used_ff, letter_used_in;
   cell_type           fill_count_ff, fill_count_in;
   logic               square_done_ff, square_done_in;
   letter_type         fill_letter_ff, fill_letter_in;
   logic               direction_ff, direction_in;

   letter_type square_mem [CELLS];
   cell_type   letter_cell_mem [LETTERS];

   cell_type   pos_a_ff, pos_b_ff;
   letter_type sq_a_ff, sq_b_ff;
   letter_type out_a_ff, out_b_ff;
   logic       not_ready_ff;

   letter_type place_raw, place_letter;
   logic       place_en;
   coord_type  row_a, col_a, row_b, col_b;
   coord_type  new_row_a, new_col_a, new_row_b, new_col_b;
   cell_type   addr_a, addr_b;

   always_comb begin
      place_raw    = cmd.fill_step ? fill_letter_ff : letter_a;
      place_letter = fold_letter(place_raw);
      place_en     = ((cmd.place_key && !square_done_ff) || cmd.fill_step)
                     && (place_raw <= LETTER_Z)
                     && !letter_used_ff[place_letter]
                     && (fill_count_ff < CELL_COUNT);
   end

   always_comb begin
      letter_used_in = letter_used_ff;
      fill_count_in  = fill_count_ff;
      square_done_in = square_done_ff;
      fill_letter_in = fill_letter_ff;
      direction_in   = csr_write_enable ? csr_write_data : direction_ff;
      if (cmd.clear) begin
         letter_used_in = '0;
         fill_count_in  = '0;
         square_done_in = 1'b0;
      end
      if (place_en) begin
         letter_used_in[place_letter] = 1'b1;
         fill_count_in = cell_type'(fill_count_ff + 5'd1);
      end
      if (cmd.fill_start) begin
         fill_letter_in = '0;
      end else if (cmd.fill_step) begin
         fill_letter_in = letter_type'(fill_letter_ff + 5'd1);
         if (fill_letter_ff == LETTER_Z) begin
            square_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_used_ff <= '0;
         fill_count_ff  <= '0;
         square_done_ff <= 1'b0;
         fill_letter_ff <= '0;
         direction_ff   <= 1'b0;
      end else begin
         letter_used_ff <= letter_used_in;
         fill_count_ff  <= fill_count_in;
         square_done_ff <= square_done_in;
         fill_letter_ff <= fill_letter_in;
         direction_ff   <= direction_in;
      end
   end

   always_ff @(posedge clock) begin
      if (place_en) begin
         square_mem[fill_count_ff]     <= place_letter;
         letter_cell_mem[place_letter] <= fill_count_ff;
      end
      if (cmd.lookup) begin
         pos_a_ff <= letter_cell_mem[fold_letter(letter_a)];
         pos_b_ff <= letter_cell_mem[fold_letter(letter_b)];
      end
      if (cmd.square_read) begin
         sq_a_ff <= square_mem[addr_a];
         sq_b_ff <= square_mem[addr_b];
      end
   end

   always_comb begin
      row_a = cell_row(pos_a_ff);
      col_a = cell_col(pos_a_ff);
      row_b = cell_row(pos_b_ff);
      col_b = cell_col(pos_b_ff);
      if (row_a == row_b) begin
         new_row_a = row_a;
         new_col_a = step_coord(col_a, direction_ff);
         new_row_b = row_b;
         new_col_b = step_coord(col_b, direction_ff);
      end else if (col_a == col_b) begin
         new_row_a = step_coord(row_a, direction_ff);
         new_col_a = col_a;
         new_row_b = step_coord(row_b, direction_ff);
         new_col_b = col_b;
      end else begin
         new_row_a = row_a;
         new_col_a = col_b;
         new_row_b = row_b;
         new_col_b = col_a;
      end
      addr_a = cell_index(new_row_a, new_col_a);
      addr_b = cell_index(new_row_b, new_col_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_a_ff     <= square_done_ff ? sq_a_ff : '0;
         out_b_ff     <= square_done_ff ? sq_b_ff : '0;
         not_ready_ff <= !square_done_ff;
      end
   end

   assign status.square_done = square_done_ff;
   assign status.fill_last   = (fill_letter_ff == LETTER_Z);
   assign out_a     = out_a_ff;
   assign out_b     = out_b_ff;
   assign not_ready = not_ready_ff;

`ifndef SYNTHESIS
   a_fill_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(letter_used_ff) == int'(fill_count_ff))
      else $error("Fill count disagrees with the used-letter flags.");

   a_done_means_full: assert property (@(posedge clock) disable iff (reset)
      square_done_ff |-> fill_count_ff == CELL_COUNT)
      else $error("Square marked done without every cell filled.");

   a_j_never_placed: assert property (@(posedge clock) disable iff (reset)
      !letter_used_ff[LETTER_J])
      else $error("The letter J was placed in the square.");
`endif

endmodule

`default_nettype wire

// ----- hdl/pfc_controller.sv -----
// Controller state machine: request handshake, fill sequencing, pair lookup
// sequencing and the response valid register. Depends on pfc_pkg.
`default_nettype none

module pfc_controller import pfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  command_type   req_command,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_LOOK,
      ST_DELIVER
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      slot_free;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      slot_free = !rsp_valid_ff || rsp_ready;
      cmd.clear       = accept && (req_command == CMD_START);
      cmd.place_key   = accept && (req_command == CMD_KEY);
      cmd.fill_start  = accept && (req_command == CMD_FINISH) && !status.square_done;
      cmd.fill_step   = (state_ff == ST_FILL);
      cmd.lookup      = accept && (req_command == CMD_PAIR);
      cmd.square_read = (state_ff == ST_LOOK);
      cmd.rsp_load    = (state_ff == ST_DELIVER) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.fill_start) begin
                  state_ff <= ST_FILL;
               end else if (cmd.lookup) begin
                  state_ff <= ST_LOOK;
               end
            end
            ST_FILL: begin
               if (status.fill_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_LOOK: begin
               state_ff <= ST_DELIVER;
            end
            ST_DELIVER: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_pair_goes_to_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> state_ff == ST_LOOK)
      else $error("Accepted pair did not start a lookup.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("Response overwritten while still waiting.");

   a_fill_ends_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && status.fill_last) |=>
         (state_ff == ST_IDLE && status.square_done))
      else $error("Fill sweep ended without a finished square.");
`endif

endmodule

`default_nettype wire
